// ===== src/fir_filter_q8_macros.svh =====
// ----------------------------------------------------------------------------
// fir_filter_q8 assertion macros
// Shorthand for the clocked properties checked in the FIR filter.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_Q8_MACROS_SVH
`define FIR_FILTER_Q8_MACROS_SVH

// Check cons in the same cycle as ante.
`define FIRQ8_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define FIRQ8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/firq8_pkg.sv =====
// ----------------------------------------------------------------------------
// firq8_pkg
// Types and constants shared by the FIR filter modules.
// ----------------------------------------------------------------------------
package firq8_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int TAPS_W      = 6;
  localparam int IDX_W       = 5;
  localparam int SCALE_SHIFT = 8;
  localparam int OUT_W       = 16;
  // Only the low SCALE_SHIFT + OUT_W bits of the sum reach the output.
  localparam int ACC_W       = SCALE_SHIFT + OUT_W;

  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_COEF    = 2'd1,
    REQ_RESTART = 2'd2
  } req_kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [IDX_W-1:0]           coeff_index;
    logic signed [COEF_W-1:0]   coeff_value;
  } req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered_value;
    logic                    status;
  } rsp_t;

  typedef struct packed {
    logic              start;
    logic              run;
    logic              last;
    logic              clear;
    logic              coef_we;
    logic [TAPS_W-1:0] taps;
    logic [TAPS_W-1:0] pos;
    logic [IDX_W-1:0]  coef_idx;
  } cell_ctrl_t;

endpackage

// ===== src/firq8_if.sv =====
// ----------------------------------------------------------------------------
// firq8 stream interfaces
// Valid/ready channels for requests into and results out of the filter.
// ----------------------------------------------------------------------------
interface firq8_req_if;
  import firq8_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface firq8_rsp_if;
  import firq8_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/firq8_cell.sv =====
// ----------------------------------------------------------------------------
// firq8_cell
// One tap: coefficient, history sample, and a multiply-add on the token.
// ----------------------------------------------------------------------------
module firq8_cell
  import firq8_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cell_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic signed [COEF_W-1:0]   coef_wdata,
  input  logic signed [COEF_W-1:0]   coef_bcast,
  input  logic signed [COEF_W-1:0]   up_coef,
  input  logic                       up_tok,
  input  logic [ACC_W-1:0]           up_sum,
  output logic signed [COEF_W-1:0]   coef,
  output logic                       tok,
  output logic [ACC_W-1:0]           sum
);

  logic signed [SAMPLE_W-1:0]        hist;
  logic [ACC_W-1:0]                  acc;
  logic signed [COEF_W+SAMPLE_W-1:0] prod;
  logic                              in_ring;
  logic                              here;
  logic                              coef_hit;

  assign in_ring  = IDX < int'(ctrl.taps);
  assign here     = int'(ctrl.pos) == IDX;
  assign coef_hit = int'(ctrl.coef_idx) == IDX;

  assign prod = coef_bcast * hist;
  assign sum  = tok ? acc + prod[ACC_W-1:0] : '0;

  // Load a written coefficient, else rotate the ring by one per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (ctrl.coef_we && coef_hit) begin
      coef <= coef_wdata;
    end else if (ctrl.run && in_ring) begin
      coef <= up_coef;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (ctrl.clear) begin
      hist <= '0;
    end else if (ctrl.start && here) begin
      hist <= sample;
    end
  end

  // Plant the token on a start; drop it after the last step.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (ctrl.start) begin
      tok <= here;
    end else if (ctrl.run) begin
      tok <= up_tok && in_ring && !ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc <= '0;
    end else if (ctrl.run) begin
      acc <= up_sum;
    end
  end

endmodule

// ===== src/fir_filter_q8.sv =====
// ----------------------------------------------------------------------------
// fir_filter_q8
// A coefficient write, restart or refused sample gives its result in the
// cycle after the request; a sample gives it once the token has walked
// all n cells of the tap ring, and no request is taken until then. Other
// requests are taken one a cycle while the output register is free.
// Reset (synchronous): coefficients, history, position and num_taps clear.
// ----------------------------------------------------------------------------
`include "fir_filter_q8_macros.svh"

module fir_filter_q8
  import firq8_pkg::*;
#(
  parameter int MAX_TAPS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              num_taps_we,
  input  logic [TAPS_W-1:0] num_taps_wdata,
  firq8_req_if.sink         req,
  firq8_rsp_if.source       rsp
);

  // The history lives in a row of cells, one per tap, at fixed positions.
  // A sample request writes the new sample at the current position and
  // plants a token there. Each step the token, carrying the partial sum,
  // moves one cell down the ring of the first n cells (cell 0 wraps to
  // cell n-1), while the coefficient ring rotates so cell 0 always shows
  // the coefficient for the current step. After n steps the coefficient
  // ring is back where it started and the token holds the full sum.

  state_t              state;
  state_t              state_next;
  logic [TAPS_W-1:0]   num_taps;
  logic [TAPS_W-1:0]   n_eff;
  logic [TAPS_W-1:0]   pos;
  logic [TAPS_W-1:0]   pos_eff;
  logic [TAPS_W-1:0]   step;
  logic                last;
  logic                out_free;
  logic                req_ready;
  logic                req_fire;
  logic                is_sample;
  logic                is_coef;
  logic                is_restart;
  logic                start;
  logic                run_en;
  logic                out_load;
  rsp_t                out_load_data;
  logic                out_valid;
  rsp_t                out_data;
  cell_ctrl_t          ctrl;
  logic [ACC_W-1:0]    sum_or;

  logic signed [COEF_W-1:0] coef_vec [MAX_TAPS];
  logic [MAX_TAPS-1:0]      tok_vec;
  logic [ACC_W-1:0]         sum_vec  [MAX_TAPS];

  // Clamp the tap count to the cells built.
  assign n_eff   = (int'(num_taps) > MAX_TAPS) ? TAPS_W'(MAX_TAPS) : num_taps;
  // Saturate a stale position after the tap count was lowered.
  assign pos_eff = (pos < n_eff) ? pos : n_eff - TAPS_W'(1);
  assign last    = step == n_eff - TAPS_W'(1);

  assign out_free = !out_valid || rsp.ready;
  assign req.ready = req_ready;
  assign req_fire  = req.valid && req_ready;

  always_comb begin
    is_sample  = 1'b0;
    is_coef    = 1'b0;
    is_restart = 1'b0;
    unique case (req_kind_t'(req.data.req_type))
      REQ_SAMPLE:  is_sample  = 1'b1;
      REQ_COEF:    is_coef    = 1'b1;
      REQ_RESTART: is_restart = 1'b1;
      default:     ;
    endcase
  end

  assign start = req_fire && is_sample && (n_eff != '0);

  // ---------------------------------------------------------------------
  // Control state machine
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_RUN;
      ST_RUN:  if (run_en && last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Take requests only when idle; hold the last step while output is full.
  always_comb begin
    req_ready = 1'b0;
    run_en    = 1'b0;
    unique case (state)
      ST_IDLE: req_ready = out_free;
      ST_RUN:  run_en    = !last || out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_taps <= '0;
    end else if (num_taps_we) begin
      num_taps <= num_taps_wdata;
    end
  end

  // Step the position down per sample, wrapping to n-1; restart zeroes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (req_fire && is_restart) begin
      pos <= '0;
    end else if (start) begin
      pos <= (pos_eff == '0) ? n_eff - TAPS_W'(1) : pos_eff - TAPS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (start) begin
      step <= '0;
    end else if (run_en) begin
      step <= last ? '0 : step + TAPS_W'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------
  assign ctrl.start    = start;
  assign ctrl.run      = run_en;
  assign ctrl.last     = last;
  assign ctrl.clear    = req_fire && is_restart;
  assign ctrl.coef_we  = req_fire && is_coef && (int'(req.data.coeff_index) < MAX_TAPS);
  assign ctrl.taps     = n_eff;
  assign ctrl.pos      = pos_eff;
  assign ctrl.coef_idx = req.data.coeff_index;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    localparam int NXT = (k + 1) % MAX_TAPS;
    logic ring_end;
    logic signed [COEF_W-1:0] up_coef;
    logic                     up_tok;
    logic [ACC_W-1:0]         up_sum;

    // The top cell of the ring takes its neighbor data from cell 0.
    assign ring_end = int'(n_eff) == k + 1;
    assign up_coef  = ring_end ? coef_vec[0] : coef_vec[NXT];
    assign up_tok   = ring_end ? tok_vec[0]  : tok_vec[NXT];
    assign up_sum   = ring_end ? sum_vec[0]  : sum_vec[NXT];

    firq8_cell #(
      .IDX (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .sample     (req.data.sample_value),
      .coef_wdata (req.data.coeff_value),
      .coef_bcast (coef_vec[0]),
      .up_coef    (up_coef),
      .up_tok     (up_tok),
      .up_sum     (up_sum),
      .coef       (coef_vec[k]),
      .tok        (tok_vec[k]),
      .sum        (sum_vec[k])
    );
  end

  // Only the token cell drives a nonzero sum.
  always_comb begin
    sum_or = '0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      sum_or = sum_or | sum_vec[k];
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_comb begin
    out_load      = 1'b0;
    out_load_data = '0;
    if (req_fire && !start) begin
      // Non-sample request, or a sample refused with no taps configured.
      out_load             = 1'b1;
      out_load_data.status = is_sample;
    end else if (run_en && last) begin
      out_load                     = 1'b1;
      out_load_data.filtered_value = sum_or[SCALE_SHIFT +: OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_load_data;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `FIRQ8_ASSERT(a_tok_onehot0, 1'b1, $onehot0(tok_vec), "more than one token in the ring")
  `FIRQ8_ASSERT(a_run_has_tok, state == ST_RUN, $onehot(tok_vec), "running without a token")
  `FIRQ8_ASSERT(a_idle_no_tok, state == ST_IDLE, tok_vec == '0, "token left while idle")
  `FIRQ8_ASSERT_NEXT(a_finish_out, run_en && last, rsp.valid, "finished sum not presented")

endmodule
